>>> hw/rtl/jsu_pkg.sv
// Shared types, codes and character constants for the JSON string unescaper.
// No dependencies; imported by jsu_decode and json_string_unescape_unit.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

  // Scanner mode. Codes 6 and 7 are unused and decode as normal text.
  typedef enum logic [2:0] {
    MODE_TEXT = 3'd0,
    MODE_ESC  = 3'd1,
    MODE_HEX1 = 3'd2,
    MODE_HEX2 = 3'd3,
    MODE_HEX3 = 3'd4,
    MODE_HEX4 = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    KIND_BYTE   = 3'd0,
    KIND_END    = 3'd1,
    KIND_CTRL   = 3'd2,
    KIND_BADESC = 3'd3,
    KIND_BADHEX = 3'd4
  } kind_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_LC_B = 8'h62;
  localparam logic [7:0] CH_LC_F = 8'h66;
  localparam logic [7:0] CH_LC_N = 8'h6E;
  localparam logic [7:0] CH_LC_R = 8'h72;
  localparam logic [7:0] CH_LC_T = 8'h74;
  localparam logic [7:0] CH_LC_U = 8'h75;
  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_FF = 8'h0C;
  localparam logic [7:0] CODE_LF = 8'h0A;
  localparam logic [7:0] CODE_CR = 8'h0D;
  localparam logic [7:0] CODE_TAB = 8'h09;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } hex_t;

  // One decoded result of the scanner.
  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] value;
  } res_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok = 1'b1;
    h.digit = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.digit = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/jsu_decode.sv
// Next-state and result logic of the unescaper for one byte.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_decode (
  input  wire jsu_pkg::mode_t mode,
  input  wire [7:0]           acc,
  input  wire [7:0]           c,
  output jsu_pkg::mode_t      mode_next,
  output logic [7:0]          acc_next,
  output jsu_pkg::res_t       res
);
  import jsu_pkg::*;

  hex_t       h;
  logic [7:0] acc_sh;

  assign h = hex_decode(c);
  assign acc_sh = {acc[3:0], h.digit};

  always_comb begin
    mode_next = MODE_TEXT;
    acc_next = acc;
    res.emit = 1'b0;
    res.kind = KIND_BYTE;
    res.value = 8'd0;
    unique case (mode) inside
      MODE_ESC: begin
        res.emit = 1'b1;
        case (c)
          CH_QUOTE:  res.value = CH_QUOTE;
          CH_BSLASH: res.value = CH_BSLASH;
          CH_SLASH:  res.value = CH_SLASH;
          CH_LC_B:   res.value = CODE_BS;
          CH_LC_F:   res.value = CODE_FF;
          CH_LC_N:   res.value = CODE_LF;
          CH_LC_R:   res.value = CODE_CR;
          CH_LC_T:   res.value = CODE_TAB;
          CH_LC_U: begin
            res.emit = 1'b0;
            mode_next = MODE_HEX1;
            acc_next = 8'd0;
          end
          default:   res.kind = KIND_BADESC;
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (!h.ok) begin
          acc_next = 8'd0;
          res.emit = 1'b1;
          res.kind = KIND_BADHEX;
        end else if (mode == MODE_HEX4) begin
          acc_next = 8'd0;
          res.emit = 1'b1;
          res.value = acc_sh;
        end else begin
          acc_next = acc_sh;
          mode_next = mode_t'(mode + 3'd1);
        end
      end
      default: begin
        // normal text
        res.emit = 1'b1;
        if (c == CH_QUOTE) begin
          res.kind = KIND_END;
        end else if (c == CH_BSLASH) begin
          res.emit = 1'b0;
          mode_next = MODE_ESC;
        end else if (c < CH_SPACE || c == CH_DEL) begin
          res.kind = KIND_CTRL;
        end else begin
          res.value = c;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/json_string_unescape_unit.sv
// Top level of the JSON string unescaper: input register, scanner state,
// result register. Depends on jsu_pkg and jsu_decode.
`timescale 1ns / 1ps
`default_nettype none

// Decodes the body of a JSON string, one byte per request, starting just
// after the opening quote. Each byte gives zero or one result: a decoded
// byte (kind 0), end of string on a closing quote (kind 1), or an error
// for a raw control byte (kind 2), an unknown escape (kind 3) or a non-hex
// digit in \u (kind 4). last is set on every kind but 0, and after it the
// scanner is back in its start state for the next string. A backslash,
// the u of \u and the first three digits of \u give no result; \u yields
// only the low byte of its code unit. Bytes 128-255 pass through.
// Rate: one byte per cycle sustained while out_stall holds nothing back. A
// byte sits in the input register until the result register can take it,
// is decoded against the scanner mode, and its result lands in the result
// register, from which it leaves. The result register is the only place a
// stall backs up, so out_stall reaches in_stall only when both registers
// are full.
module json_string_unescape_unit (
  input  wire        clk,
  input  wire        rst,
  // input channel
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] char_in,
  // result channel
  output logic       out_valid,
  input  wire        out_stall,
  output logic [2:0] kind,
  output logic [7:0] value,
  output logic       last
);
  import jsu_pkg::*;

  // input register
  logic       hold_valid;
  logic [7:0] hold_char;

  // scanner state
  mode_t      mode;
  mode_t      mode_next;
  logic [7:0] acc;
  logic [7:0] acc_next;

  res_t       res;
  logic       out_free;  // result register can take a new entry
  logic       step;      // held byte is decoded this cycle

  assign out_free = !out_valid || !out_stall;
  assign step = hold_valid && out_free;
  // Input register frees whenever its byte is decoded.
  assign in_stall = hold_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      hold_char <= char_in;
    end
  end

  jsu_decode u_decode (
    .mode      (mode),
    .acc       (acc),
    .c         (hold_char),
    .mode_next (mode_next),
    .acc_next  (acc_next),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_TEXT;
      acc <= 8'd0;
    end else if (step) begin
      mode <= mode_next;
      acc <= acc_next;
    end
  end

  // result register; a byte without a result simply drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step && res.emit;
    end
    if (step && res.emit) begin
      kind <= res.kind;
      value <= res.value;
      last <= (res.kind != KIND_BYTE);
    end
  end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking bench for json_string_unescape_unit: random and directed byte
// streams go in, decoded bytes and end/error markers are checked as they come out.
// Depends on jsu_pkg (mode and kind codes, character constants) and the RTL.
`timescale 1ns / 1ps

module tb_top;
  import jsu_pkg::*;

  localparam int RANDOM_BYTES = 600;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no request moving on either side
  localparam int MAX_REPORTS  = 10;

  // One expected result of the unescaper.
  typedef struct {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } decoded_t;

  // Receiver stall patterns, switched at random by the receiver.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_COIN,
    STALL_MOSTLY,
    STALL_RUNS
  } stall_style_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] char_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [2:0] kind;
  logic [7:0] value;
  logic       last;

  json_string_unescape_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .char_in  (char_in),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind     (kind),
    .value    (value),
    .last     (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Raw string body bytes waiting to be sent, and decoded results still owed.
  logic [7:0] body_q[$];
  decoded_t   decoded_q[$];

  // Scanner state as the bench sees it.
  mode_t      scan_mode = MODE_TEXT;
  logic [7:0] hex_acc = 8'h00;

  int fail_count = 0;
  int reports = 0;
  int n_directed = 0;
  int idle_cycles = 0;
  logic byte_taken = 1'b0;

  localparam logic [7:0] ESC_LETTERS[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LC_B,
                                            CH_LC_F, CH_LC_N, CH_LC_R, CH_LC_T};

  // Hex digit as ASCII, upper or lower case at random.
  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return 8'(8'h30 + v);
    return ($urandom_range(0, 1) != 0) ? 8'(8'h41 + v - 10) : 8'(8'h61 + v - 10);
  endfunction

  // Append one raw byte to the send queue.
  task automatic put_byte(input logic [7:0] b);
    body_q.insert(body_q.size(), b);
  endtask

  // Advance the scanner by one accepted byte and queue whatever it must emit.
  task automatic unescape_byte(input logic [7:0] c);
    decoded_t r;
    int       d;
    logic     emits;
    emits   = 1'b1;
    r.kind  = KIND_BYTE;
    r.value = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) d = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) d = c - 8'h61 + 10;
    else if (c >= 8'h41 && c <= 8'h46) d = c - 8'h41 + 10;
    else d = -1;
    case (scan_mode)
      MODE_ESC: begin
        scan_mode = MODE_TEXT;
        case (c)
          CH_QUOTE, CH_BSLASH, CH_SLASH: r.value = c;
          CH_LC_B: r.value = CODE_BS;
          CH_LC_F: r.value = CODE_FF;
          CH_LC_N: r.value = CODE_LF;
          CH_LC_R: r.value = CODE_CR;
          CH_LC_T: r.value = CODE_TAB;
          CH_LC_U: begin
            scan_mode = MODE_HEX1;
            hex_acc   = 8'h00;
            emits     = 1'b0;
          end
          default: r.kind = KIND_BADESC;
        endcase
      end
      MODE_HEX1, MODE_HEX2, MODE_HEX3, MODE_HEX4: begin
        if (d < 0) begin
          scan_mode = MODE_TEXT;
          hex_acc   = 8'h00;
          r.kind    = KIND_BADHEX;
        end else begin
          // only the low byte of the code unit survives
          hex_acc = {hex_acc[3:0], 4'(d)};
          if (scan_mode == MODE_HEX4) begin
            r.value   = hex_acc;
            scan_mode = MODE_TEXT;
            hex_acc   = 8'h00;
          end else begin
            scan_mode = mode_t'(scan_mode + 3'd1);
            emits     = 1'b0;
          end
        end
      end
      default: begin
        scan_mode = MODE_TEXT;
        if (c == CH_QUOTE) begin
          r.kind = KIND_END;
        end else if (c == CH_BSLASH) begin
          scan_mode = MODE_ESC;
          emits     = 1'b0;
        end else if (c < CH_SPACE || c == CH_DEL) begin
          r.kind = KIND_CTRL;
        end else begin
          r.value = c;  // printable and high bytes pass through
        end
      end
    endcase
    r.last = (r.kind != KIND_BYTE);
    if (emits) decoded_q.insert(decoded_q.size(), r);
  endtask

  // Stimulus: a short directed string, then random string bodies with noise.
  initial begin
    int pick;
    int len;
    int tok;
    logic [7:0] c;
    // control bytes, high bytes, lowest printable
    put_byte(8'h00);
    put_byte(CH_DEL);
    put_byte(8'h1F);
    put_byte(8'hFF);
    put_byte(8'h80);
    put_byte(CH_SPACE);
    // simple escapes
    put_byte(CH_BSLASH); put_byte(CH_QUOTE);
    put_byte(CH_BSLASH); put_byte(CH_SLASH);
    put_byte(CH_BSLASH); put_byte(CH_BSLASH);
    // \uA0f9: mixed case digits, gives 0xF9
    put_byte(CH_BSLASH); put_byte(CH_LC_U);
    put_byte(8'h41); put_byte(8'h30);
    put_byte(8'h66); put_byte(8'h39);
    // unknown escape letter, then a non-hex digit inside \u
    put_byte(CH_BSLASH); put_byte(8'h71);
    put_byte(CH_BSLASH); put_byte(CH_LC_U); put_byte(8'h67);
    // closing quote
    put_byte(CH_QUOTE);
    n_directed = body_q.size();

    while (body_q.size() < n_directed + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        // well-formed body with random content
        len = $urandom_range(0, 10);
        repeat (len) begin
          tok = $urandom_range(0, 9);
          if (tok < 6) begin
            c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(8'h80, 8'hFF))
                                            : 8'($urandom_range(8'h20, 8'h7E));
            if (c == CH_QUOTE || c == CH_BSLASH) c = CH_SPACE;
            put_byte(c);
          end else if (tok < 8) begin
            put_byte(CH_BSLASH);
            put_byte(ESC_LETTERS[$urandom_range(0, 7)]);
          end else begin
            put_byte(CH_BSLASH);
            put_byte(CH_LC_U);
            repeat (4) put_byte(hex_char($urandom_range(0, 15)));
          end
        end
        put_byte(CH_QUOTE);
      end else if (pick < 90) begin
        // raw noise, any byte
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      end else if (pick < 95) begin
        // escape with an arbitrary follower
        put_byte(CH_BSLASH);
        put_byte(8'($urandom_range(0, 255)));
      end else begin
        // \u cut short by an arbitrary byte
        put_byte(CH_BSLASH);
        put_byte(CH_LC_U);
        repeat ($urandom_range(0, 3)) put_byte(hex_char($urandom_range(0, 15)));
        put_byte(8'($urandom_range(0, 255)));
      end
    end

    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // all requests sent, then all results back, then a short tail for strays
    while (body_q.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Sender: bursts of requests with random gaps. Once after the directed part,
  // and now and then at a burst boundary, it holds off until nothing is owed.
  int   burst_left = 1;
  int   gap_left = 0;
  int   sent = 0;
  logic drain_hold = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      char_in  <= 8'h00;
    end else if (!in_valid || byte_taken) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (drain_hold) begin
        in_valid <= 1'b0;
        if (decoded_q.size() == 0) drain_hold = 1'b0;
      end else if (body_q.size() != 0) begin
        in_valid <= 1'b1;
        char_in  <= body_q.pop_front();
        sent = sent + 1;
        if (sent == n_directed) drain_hold = 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          if ($urandom_range(0, 15) == 0) drain_hold = 1'b1;
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern changes style at random.
  stall_style_t stall_style = STALL_NONE;
  int           style_left = 0;
  int           run_left = 0;
  logic         run_stalled = 1'b0;
  logic [1:0]   stall_tick = 2'd0;

  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = stall_style_t'($urandom_range(0, 3));
        style_left  = $urandom_range(20, 80);
      end else begin
        style_left = style_left - 1;
      end
      stall_tick = stall_tick + 2'd1;
      case (stall_style)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_COIN:   out_stall <= 1'($urandom_range(0, 1));
        STALL_MOSTLY: out_stall <= (stall_tick != 2'd0);
        default: begin
          if (run_left == 0) begin
            run_stalled = !run_stalled;
            run_left    = $urandom_range(1, 12);
          end else begin
            run_left = run_left - 1;
          end
          out_stall <= run_stalled;
        end
      endcase
    end
  end

  // Monitor: predicts on each accepted request, checks each accepted result,
  // and watches for a stuck pipeline.
  always @(posedge clk) begin
    decoded_t want;
    if (rst) begin
      byte_taken  <= 1'b0;
      scan_mode   = MODE_TEXT;
      hex_acc     = 8'h00;
      idle_cycles = 0;
    end else begin
      byte_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall) unescape_byte(char_in);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          fail_count = fail_count + 1;
          if (reports < MAX_REPORTS) begin
            $display("unexpected result: kind %0d value %02h last %0d", kind, value, last);
            reports = reports + 1;
          end
        end else begin
          want = decoded_q.pop_front();
          if (kind !== want.kind || value !== want.value || last !== want.last) begin
            fail_count = fail_count + 1;
            if (reports < MAX_REPORTS) begin
              $display("mismatch: got kind %0d value %02h last %0d, want kind %0d value %02h last %0d",
                       kind, value, last, want.kind, want.value, want.last);
              reports = reports + 1;
            end
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

endmodule

>>> files.f
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_decode.sv
hw/rtl/json_string_unescape_unit.sv
dv/tb_top.sv
